[sv/zmpc_pkg.sv]
`default_nettype none
package zmpc_pkg;

   localparam int DIV_STEPS = 15;

   typedef struct packed {
      logic [15:0] ref_sample;
      logic [15:0] cand_sample;
   } req_type;

   typedef struct packed {
      logic signed [15:0] correlation;
      logic               corr_valid;
   } rsp_type;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_MLOAD  = 9'b000000010,
      S_MRUN   = 9'b000000100,
      S_MSTORE = 9'b000001000,
      S_RLOAD  = 9'b000010000,
      S_ROOT   = 9'b000100000,
      S_DINIT  = 9'b001000000,
      S_DIV    = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      SEL_N_RR = 3'd0,
      SEL_R_R  = 3'd1,
      SEL_N_CC = 3'd2,
      SEL_C_C  = 3'd3,
      SEL_N_RC = 3'd4,
      SEL_R_C  = 3'd5,
      SEL_V    = 3'd6
   } sel_type;

   typedef struct packed {
      logic    accum;
      logic    clear;
      logic    mul_load;
      logic    mul_step;
      logic    mul_store;
      sel_type sel;
      logic    root_load;
      logic    root_step;
      logic    div_init;
      logic    div_step;
      logic    rsp_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic d_zero;
   } status_type;

endpackage
`default_nettype wire

[sv/zmpc_dp.sv]
`default_nettype none
module zmpc_dp import zmpc_pkg::*; #(
   parameter int MAX_HALF    = 15,
   parameter int SAMPLE_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  req_type     req_data,
   input  wire         csr_write,
   input  wire  [3:0]  csr_data,
   output rsp_type     rsp_data
);

   localparam int NB = $clog2((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1) + 1);
   localparam int SB = SAMPLE_BITS;
   localparam int SW = SB + NB;
   localparam int QW = 2 * SB + NB;
   localparam int MW = 2 * SB + 2 * NB;
   localparam int PW = 2 * MW;

   logic [3:0]    whalf_ff;
   logic [NB-1:0] count_ff;
   logic [SW-1:0] s0_ff, s1_ff;
   logic [QW-1:0] s00_ff, s11_ff, s01_ff;
   logic [PW-1:0] ma_ff, prod_ff, rad_ff;
   logic [MW-1:0] mb_ff, tmp_ff, v0_ff, v1_ff, mag_ff, root_ff;
   logic          neg_ff;
   logic [MW+1:0] rem_ff;
   logic [MW:0]   r_ff;
   logic [15:0]   quo_ff;
   rsp_type       rsp_ff;

   logic [4:0]    h5, hsat;
   logic [5:0]    side;
   logic [11:0]   n_full;
   logic [NB-1:0] n, count_inc;
   logic [SB-1:0] a, b;
   logic [2*SB-1:0] aa, bb, ab;
   logic [MW-1:0] opa, opb, plo;
   logic [MW+1:0] rem_sh, trial;
   logic [MW:0]   r2;
   rsp_type       rsp_in;

   always_comb begin
      h5        = {1'b0, whalf_ff};
      hsat      = (h5 > 5'(MAX_HALF)) ? 5'(MAX_HALF) : h5;
      side      = {hsat, 1'b1};
      n_full    = {6'd0, side} * {6'd0, side};
      n         = NB'(n_full);
      count_inc = count_ff + NB'(1);
      a         = req_data.ref_sample[SB-1:0];
      b         = req_data.cand_sample[SB-1:0];
      aa        = a * a;
      bb        = b * b;
      ab        = a * b;
      plo       = prod_ff[MW-1:0];
      rem_sh    = {rem_ff[MW-1:0], rad_ff[PW-1:PW-2]};
      trial     = {root_ff, 2'b01};
      r2        = {r_ff[MW-1:0], 1'b0};
      status.last   = (count_inc == n);
      status.d_zero = (root_ff == '0);
      case (cmd.sel)
         SEL_N_RR: begin opa = MW'(n);      opb = MW'(s00_ff); end
         SEL_R_R:  begin opa = MW'(s0_ff);  opb = MW'(s0_ff);  end
         SEL_N_CC: begin opa = MW'(n);      opb = MW'(s11_ff); end
         SEL_C_C:  begin opa = MW'(s1_ff);  opb = MW'(s1_ff);  end
         SEL_N_RC: begin opa = MW'(n);      opb = MW'(s01_ff); end
         SEL_R_C:  begin opa = MW'(s0_ff);  opb = MW'(s1_ff);  end
         SEL_V:    begin opa = v0_ff;       opb = v1_ff;       end
         default:  begin opa = '0;          opb = '0;          end
      endcase
      if (status.d_zero) begin
         rsp_in.correlation = '0;
         rsp_in.corr_valid  = 1'b0;
      end else if (neg_ff) begin
         rsp_in.correlation = ~quo_ff + 16'd1;
         rsp_in.corr_valid  = 1'b1;
      end else begin
         rsp_in.correlation = quo_ff[15] ? 16'h7fff : quo_ff;
         rsp_in.corr_valid  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whalf_ff <= 4'd5;
         count_ff <= '0;
         s0_ff    <= '0;
         s1_ff    <= '0;
         s00_ff   <= '0;
         s11_ff   <= '0;
         s01_ff   <= '0;
      end else if (csr_write || cmd.clear) begin
         if (csr_write) begin
            whalf_ff <= csr_data;
         end
         count_ff <= '0;
         s0_ff    <= '0;
         s1_ff    <= '0;
         s00_ff   <= '0;
         s11_ff   <= '0;
         s01_ff   <= '0;
      end else if (cmd.accum) begin
         count_ff <= count_inc;
         s0_ff    <= s0_ff + SW'(a);
         s1_ff    <= s1_ff + SW'(b);
         s00_ff   <= s00_ff + QW'(aa);
         s11_ff   <= s11_ff + QW'(bb);
         s01_ff   <= s01_ff + QW'(ab);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         ma_ff   <= PW'(opa);
         mb_ff   <= opb;
         prod_ff <= '0;
      end else if (cmd.mul_step) begin
         if (mb_ff[0]) begin
            prod_ff <= prod_ff + ma_ff;
         end
         ma_ff <= {ma_ff[PW-2:0], 1'b0};
         mb_ff <= {1'b0, mb_ff[MW-1:1]};
      end
      if (cmd.mul_store) begin
         case (cmd.sel)
            SEL_N_RR, SEL_N_CC, SEL_N_RC: tmp_ff <= plo;
            SEL_R_R: v0_ff <= tmp_ff - plo;
            SEL_C_C: v1_ff <= tmp_ff - plo;
            SEL_R_C: begin
               neg_ff <= (tmp_ff < plo);
               mag_ff <= (tmp_ff < plo) ? plo - tmp_ff : tmp_ff - plo;
            end
            SEL_V:   rad_ff <= prod_ff;
            default: tmp_ff <= tmp_ff;
         endcase
      end
      if (cmd.root_load) begin
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[MW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[MW-2:0], 1'b0};
         end
         rad_ff <= {rad_ff[PW-3:0], 2'b00};
      end
      if (cmd.div_init) begin
         if (mag_ff >= root_ff) begin
            quo_ff <= 16'd1;
            r_ff   <= '0;
         end else begin
            quo_ff <= 16'd0;
            r_ff   <= {1'b0, mag_ff};
         end
      end else if (cmd.div_step) begin
         if (r2 >= {1'b0, root_ff}) begin
            r_ff   <= r2 - {1'b0, root_ff};
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            r_ff   <= r2;
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

[sv/zmpc_ctrl.sv]
`default_nettype none
module zmpc_ctrl import zmpc_pkg::*; #(
   parameter int MUL_STEPS = 52
) (
   input  wire         clock,
   input  wire         reset,
   input  status_type  status,
   output cmd_type     cmd,
   input  wire         req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire         rsp_ready
);

   localparam int STEP_W = $clog2(MUL_STEPS);

   state_type         state_ff, state_in;
   sel_type           sel_ff, sel_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      step_in      = step_ff + STEP_W'(1);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.sel      = sel_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (status.last) begin
                  sel_in   = SEL_N_RR;
                  state_in = S_MLOAD;
               end
            end
         end
         S_MLOAD: begin
            cmd.mul_load = 1'b1;
            step_in      = '0;
            state_in     = S_MRUN;
         end
         S_MRUN: begin
            cmd.mul_step = 1'b1;
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               state_in = S_MSTORE;
            end
         end
         S_MSTORE: begin
            cmd.mul_store = 1'b1;
            state_in      = S_MLOAD;
            case (sel_ff)
               SEL_N_RR: sel_in = SEL_R_R;
               SEL_R_R:  sel_in = SEL_N_CC;
               SEL_N_CC: sel_in = SEL_C_C;
               SEL_C_C:  sel_in = SEL_N_RC;
               SEL_N_RC: sel_in = SEL_R_C;
               SEL_R_C:  sel_in = SEL_V;
               default:  state_in = S_RLOAD;
            endcase
         end
         S_RLOAD: begin
            cmd.root_load = 1'b1;
            step_in       = '0;
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = status.d_zero ? S_DONE : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= SEL_N_RR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[sv/zero_mean_patch_correlation.sv]
// Zero-mean normalized cross-correlation over a square window of pixel pairs.
// req channel: one word per pair (reference pixel, candidate pixel), taken
//   one per cycle while the window fills.
// csr channel: one word writes the window half width h (always ready); the
//   window holds (2h+1)^2 pairs, h capped at MAX_HALF; any write restarts it.
// rsp channel: one word per full window, correlation in Q1.15 and a valid
//   flag that is low when either patch has zero variance.
// After the last pair of a window a shift-add multiplier runs seven products
//   on M-bit operands, with M = 2*SAMPLE_BITS + 2*ceil(log2(Nmax+1)); then a
//   digit-by-digit root of M bits, a restoring divide (skipped on zero
//   variance) and the output load follow, during which req is not ready.
//   The pairs of a new window are thus taken only once the result is loaded.
// The result waits in an output register; the next window fills while it
//   is stalled, and only the following result waits for the receiver.
// Reset (synchronous) sets h to 5, clears the sums and drops any result.
`default_nettype none
module zero_mean_patch_correlation import zmpc_pkg::*; #(
   parameter int MAX_HALF    = 15,
   parameter int SAMPLE_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output rsp_type     rsp_data,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [3:0]  csr_data
);

   localparam int NB = $clog2((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1) + 1);
   localparam int MW = 2 * SAMPLE_BITS + 2 * NB;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   zmpc_ctrl #(
      .MUL_STEPS(MW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   zmpc_dp #(
      .MAX_HALF    (MAX_HALF),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
